// File: rtl/ascii_command_alu_macros.svh
// ----------------------------------------------------------------------------
// ascii_command_alu assertion macros
// Shared property wrappers for the command calculator checkers.
// ----------------------------------------------------------------------------
`ifndef ASCII_COMMAND_ALU_MACROS_SVH
`define ASCII_COMMAND_ALU_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ACA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/aca_pkg.sv
// ----------------------------------------------------------------------------
// aca_pkg
// Types and constants shared by the ASCII command calculator.
// ----------------------------------------------------------------------------
package aca_pkg;

  // Decoded operation
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // Line status
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_MISSING   = 3'd2,
    ST_BAD_MNEM  = 3'd3,
    ST_BAD_DIGIT = 3'd4,
    ST_DIV_ZERO  = 3'd5
  } status_t;

  // Character codes
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Packed mnemonics, first byte in the top
  localparam logic [23:0] MNEM_ADD = 24'h414444;
  localparam logic [23:0] MNEM_SUB = 24'h535542;
  localparam logic [23:0] MNEM_MUL = 24'h4D554C;
  localparam logic [23:0] MNEM_DIV = 24'h444956;

  // Data width and iteration count of the shared unit
  localparam int DATA_W    = 32;
  localparam int ALU_STEPS = DATA_W;
  localparam int STEP_W    = $clog2(ALU_STEPS);

  // Request into the shared unit
  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  // Response from the shared unit
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] value;
  } alu_rsp_t;

endpackage

// File: rtl/ascii_command_alu.sv
// ----------------------------------------------------------------------------
// ascii_command_alu
// Line-oriented ASCII calculator: parses "OP A B" lines and answers each
// newline up to the first error with a status, the decoded operation and a 32-bit result.
// ----------------------------------------------------------------------------
// An ordinary character never stalls the input. A newline stalls the input
// until its result is loaded into the output register. An error line goes
// there directly; a good line first runs on the shared 33-bit adder, MUL and
// DIV for its 32 shift-add or restoring-divide steps. A finished result waits
// in the output register while the next line's characters are taken. After
// any error status every further byte is accepted and dropped until reset.
module ascii_command_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [1:0]         out_opcode,
  output logic signed [31:0] out_value
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_OUT
  } state_t;

  state_t                     state_r;
  logic                       halted_r;
  logic [1:0]                 phase_r;
  logic                       has_chars_r;
  logic [23:0]                mnem_r;
  logic [2:0]                 mnem_len_r;
  logic [aca_pkg::DATA_W-1:0] first_r;
  logic [aca_pkg::DATA_W-1:0] second_r;
  logic                       bad_digit_r;
  aca_pkg::status_t           stat_r;
  aca_pkg::op_t               op_r;
  logic [aca_pkg::DATA_W-1:0] val_r;

  logic                       out_valid_r;
  logic [2:0]                 out_status_r;
  logic [1:0]                 out_opcode_r;
  logic [aca_pkg::DATA_W-1:0] out_value_r;

  logic                       in_beat;
  logic                       is_nl;
  logic                       is_space;
  logic                       is_digit;
  logic                       op_ok;
  aca_pkg::op_t               op_c;
  aca_pkg::status_t           stat_c;
  logic [aca_pkg::DATA_W-1:0] acc_src;
  logic [aca_pkg::DATA_W-1:0] acc_nxt;
  logic                       out_free;
  aca_pkg::alu_req_t          alu_req;
  aca_pkg::alu_rsp_t          alu_rsp;

  assign in_stall = (state_r != S_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign is_nl    = (in_char_in == aca_pkg::CHAR_NL);
  assign is_space = (in_char_in == aca_pkg::CHAR_SPACE);
  assign is_digit = (in_char_in >= aca_pkg::CHAR_ZERO) && (in_char_in <= aca_pkg::CHAR_NINE);

  // Decode the mnemonic
  always_comb begin
    op_ok = (mnem_len_r == 3'd3);
    op_c  = aca_pkg::OP_ADD;
    if (mnem_r == aca_pkg::MNEM_SUB) begin
      op_c = aca_pkg::OP_SUB;
    end else if (mnem_r == aca_pkg::MNEM_MUL) begin
      op_c = aca_pkg::OP_MUL;
    end else if (mnem_r == aca_pkg::MNEM_DIV) begin
      op_c = aca_pkg::OP_DIV;
    end else if (mnem_r != aca_pkg::MNEM_ADD) begin
      op_ok = 1'b0;
    end
    if (!op_ok) begin
      op_c = aca_pkg::OP_ADD;
    end
  end

  // Rank the line errors
  always_comb begin
    if (!has_chars_r) begin
      stat_c = aca_pkg::ST_EMPTY;
    end else if (!op_ok) begin
      stat_c = aca_pkg::ST_BAD_MNEM;
    end else if (phase_r < 2'd2) begin
      stat_c = aca_pkg::ST_MISSING;
    end else if (bad_digit_r) begin
      stat_c = aca_pkg::ST_BAD_DIGIT;
    end else if (op_c == aca_pkg::OP_DIV && second_r == '0) begin
      stat_c = aca_pkg::ST_DIV_ZERO;
    end else begin
      stat_c = aca_pkg::ST_OK;
    end
  end

  // Decimal accumulate: x*10 + digit
  assign acc_src = (phase_r == 2'd1) ? first_r : second_r;
  assign acc_nxt = {acc_src[aca_pkg::DATA_W-4:0], 3'b000}
                 + {acc_src[aca_pkg::DATA_W-2:0], 1'b0}
                 + {{(aca_pkg::DATA_W-4){1'b0}}, in_char_in[3:0]};

  // Launch the arithmetic for a good line
  assign alu_req.start = in_beat && !halted_r && is_nl && (stat_c == aca_pkg::ST_OK);
  assign alu_req.op    = op_c;

  aca_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .a     (first_r),
    .b     (second_r),
    .rsp   (alu_rsp)
  );

  // Sequence the line and hold the result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      halted_r    <= 1'b0;
      phase_r     <= 2'd0;
      has_chars_r <= 1'b0;
      mnem_r      <= '0;
      mnem_len_r  <= '0;
      first_r     <= '0;
      second_r    <= '0;
      bad_digit_r <= 1'b0;
      stat_r      <= aca_pkg::ST_OK;
      op_r        <= aca_pkg::OP_ADD;
      out_valid_r <= 1'b0;
    end else begin
      // Load a new result beat, or drop the current one once taken
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_beat && !halted_r) begin
            if (is_nl) begin
              stat_r  <= stat_c;
              op_r    <= op_c;
              val_r   <= '0;
              state_r <= (stat_c == aca_pkg::ST_OK) ? S_RUN : S_OUT;
            end else begin
              has_chars_r <= 1'b1;
              if (is_space && phase_r < 2'd2) begin
                phase_r <= phase_r + 2'd1;
              end else if (phase_r == 2'd0) begin
                if (mnem_len_r < 3'd3) begin
                  mnem_r <= {mnem_r[15:0], in_char_in};
                end
                if (mnem_len_r < 3'd4) begin
                  mnem_len_r <= mnem_len_r + 3'd1;
                end
              end else if (is_digit) begin
                if (phase_r == 2'd1) begin
                  first_r <= acc_nxt;
                end else begin
                  second_r <= acc_nxt;
                end
              end else begin
                bad_digit_r <= 1'b1;
              end
            end
          end
        end
        S_RUN: begin
          if (alu_rsp.done) begin
            val_r   <= alu_rsp.value;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_status_r <= stat_r;
            out_opcode_r <= op_r;
            out_value_r  <= val_r;
            halted_r     <= (stat_r != aca_pkg::ST_OK);
            phase_r      <= 2'd0;
            has_chars_r  <= 1'b0;
            mnem_r       <= '0;
            mnem_len_r   <= '0;
            first_r      <= '0;
            second_r     <= '0;
            bad_digit_r  <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_opcode = out_opcode_r;
  assign out_value  = out_value_r;

endmodule

// File: rtl/aca_alu.sv
// ----------------------------------------------------------------------------
// aca_alu
// Iterative arithmetic unit around one 33-bit adder: single-step add and
// subtract, 32-step shift-add multiply and 32-step restoring divide.
// ----------------------------------------------------------------------------
module aca_alu (
  input  logic                             clk,
  input  logic                             rst_n,
  input  aca_pkg::alu_req_t                req,
  input  logic [aca_pkg::DATA_W-1:0]       a,
  input  logic [aca_pkg::DATA_W-1:0]       b,
  output aca_pkg::alu_rsp_t                rsp
);

  logic [aca_pkg::DATA_W-1:0] a_r;    // multiplicand, or dividend/quotient
  logic [aca_pkg::DATA_W-1:0] b_r;    // multiplier, or divisor
  logic [aca_pkg::DATA_W-1:0] acc_r;  // product, or partial remainder
  logic [aca_pkg::DATA_W-1:0] res_r;
  logic [aca_pkg::STEP_W-1:0] cnt_r;
  aca_pkg::op_t               op_r;
  logic                       busy_r;
  logic                       done_r;

  logic [aca_pkg::DATA_W:0]   add_x;
  logic [aca_pkg::DATA_W:0]   add_y;
  logic                       add_sub;
  logic [aca_pkg::DATA_W:0]   sum;
  logic                       last_step;
  logic                       quo_bit;

  // Steer the shared adder
  always_comb begin
    add_x   = {1'b0, a_r};
    add_y   = {1'b0, b_r};
    add_sub = 1'b0;
    case (op_r)
      aca_pkg::OP_ADD: begin
        add_sub = 1'b0;
      end
      aca_pkg::OP_SUB: begin
        add_sub = 1'b1;
      end
      aca_pkg::OP_MUL: begin
        add_x = {1'b0, acc_r};
        add_y = {1'b0, a_r};
      end
      aca_pkg::OP_DIV: begin
        add_x   = {acc_r, a_r[aca_pkg::DATA_W-1]};
        add_y   = {1'b0, b_r};
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  assign sum = add_x + (add_y ^ {(aca_pkg::DATA_W+1){add_sub}})
             + {{aca_pkg::DATA_W{1'b0}}, add_sub};

  assign last_step = (cnt_r == aca_pkg::STEP_W'(aca_pkg::ALU_STEPS - 1));
  // trial subtraction fits when the sign of the difference is clear
  assign quo_bit   = ~sum[aca_pkg::DATA_W];

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= aca_pkg::OP_ADD;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
        cnt_r  <= '0;
        op_r   <= req.op;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        case (op_r)
          aca_pkg::OP_ADD, aca_pkg::OP_SUB: begin
            res_r  <= sum[aca_pkg::DATA_W-1:0];
            done_r <= 1'b1;
            busy_r <= 1'b0;
          end
          aca_pkg::OP_MUL: begin
            if (b_r[0]) begin
              acc_r <= sum[aca_pkg::DATA_W-1:0];
            end
            a_r   <= {a_r[aca_pkg::DATA_W-2:0], 1'b0};
            b_r   <= {1'b0, b_r[aca_pkg::DATA_W-1:1]};
            cnt_r <= cnt_r + 1'b1;
            if (last_step) begin
              res_r  <= b_r[0] ? sum[aca_pkg::DATA_W-1:0] : acc_r;
              done_r <= 1'b1;
              busy_r <= 1'b0;
            end
          end
          aca_pkg::OP_DIV: begin
            acc_r <= quo_bit ? sum[aca_pkg::DATA_W-1:0] : add_x[aca_pkg::DATA_W-1:0];
            a_r   <= {a_r[aca_pkg::DATA_W-2:0], quo_bit};
            cnt_r <= cnt_r + 1'b1;
            if (last_step) begin
              res_r  <= {a_r[aca_pkg::DATA_W-2:0], quo_bit};
              done_r <= 1'b1;
              busy_r <= 1'b0;
            end
          end
          default: begin
            busy_r <= 1'b0;
          end
        endcase
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = res_r;

endmodule

// File: rtl/ascii_command_alu_checker.sv
// ----------------------------------------------------------------------------
// ascii_command_alu_checker
// Port-level checks on the result channel and the input handshake of the command calculator.
// ----------------------------------------------------------------------------
`include "ascii_command_alu_macros.svh"

module ascii_command_alu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [7:0]         in_char_in,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         out_status,
  input logic [1:0]         out_opcode,
  input logic signed [31:0] out_value
);

  logic in_beat;

  assign in_beat = in_valid && !in_stall;

  // Hold a stalled result beat
  `ACA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_value) && $stable(out_status) && $stable(out_opcode), "stalled result beat changed")

  // Zero the value on any error status
  `ACA_ASSERT_NOW(a_err_zero, out_valid && out_status != aca_pkg::ST_OK, out_value == 0, "error beat carries a nonzero value")

  // Divide by zero only comes from DIV
  `ACA_ASSERT_NOW(a_dz_div, out_valid && out_status == aca_pkg::ST_DIV_ZERO, out_opcode == aca_pkg::OP_DIV, "divide by zero without DIV")

  // Invalid mnemonic reports the neutral opcode
  `ACA_ASSERT_NOW(a_mnem_op, out_valid && out_status == aca_pkg::ST_BAD_MNEM, out_opcode == aca_pkg::OP_ADD, "invalid mnemonic with a decoded opcode")

  // Keep the input ready after an ordinary byte
  `ACA_ASSERT_NEXT(a_char_ready, in_beat && in_char_in != aca_pkg::CHAR_NL, !in_stall, "byte stalled the input")

endmodule

bind ascii_command_alu ascii_command_alu_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_char_in (in_char_in),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_status (out_status),
  .out_opcode (out_opcode),
  .out_value  (out_value)
);

// File: verif/tb_ascii_command_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascii_command_alu
// Self-checking bench for the ASCII command calculator. Command lines go in
// byte by byte with random sender gaps and receiver stalls. A local model of
// the parser predicts status, operation and value for every newline up to the
// first error, and each result beat is checked against the oldest prediction.
// The run closes with one error line, picked at random, and a burst of bytes that must be dropped.
// ----------------------------------------------------------------------------
module tb_ascii_command_alu;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_CHARS = 640;
  localparam int MAX_REPORTS  = 40;

  typedef logic [7:0] char_t;

  typedef struct packed {
    aca_pkg::status_t status;
    aca_pkg::op_t     op;
    logic [31:0]      value;
  } calc_result_t;

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic [7:0]         in_char_in = 8'd0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic [2:0]         out_status;
  logic [1:0]         out_opcode;
  logic signed [31:0] out_value;

  // Line parser state of the model
  logic        calc_halted;
  logic [1:0]  calc_token;
  logic        calc_has_chars;
  logic [23:0] calc_mnem;
  logic [2:0]  calc_mnem_len;
  logic [31:0] calc_lhs;
  logic [31:0] calc_rhs;
  logic        calc_bad_digit;

  calc_result_t pending_results[$];
  int           err_count   = 0;
  int           chars_taken = 0;
  int           cycle_count = 0;
  bit           no_idle     = 1'b0;

  ascii_command_alu dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char_in (in_char_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_opcode (out_opcode),
    .out_value  (out_value)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[ascii_command_alu] ERROR");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall <= !no_idle && ($urandom_range(0, 99) < 16);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("mismatch in %s at cycle %0d: got 'h%0h, expected 'h%0h",
               what, cycle_count, got, want);
  endtask

  task automatic calc_clear_line();
    calc_token     = 2'd0;
    calc_has_chars = 1'b0;
    calc_mnem      = '0;
    calc_mnem_len  = '0;
    calc_lhs       = '0;
    calc_rhs       = '0;
    calc_bad_digit = 1'b0;
  endtask

  // Close the line: decode, pick a status, compute the value
  task automatic calc_end_line();
    calc_result_t res;
    logic         op_ok;
    aca_pkg::op_t op;
    logic [31:0]  val;
    op_ok = (calc_mnem_len == 3'd3);
    op    = aca_pkg::OP_ADD;
    val   = '0;
    if (op_ok) begin
      case (calc_mnem)
        aca_pkg::MNEM_ADD: op = aca_pkg::OP_ADD;
        aca_pkg::MNEM_SUB: op = aca_pkg::OP_SUB;
        aca_pkg::MNEM_MUL: op = aca_pkg::OP_MUL;
        aca_pkg::MNEM_DIV: op = aca_pkg::OP_DIV;
        default:           op_ok = 1'b0;
      endcase
    end
    if (!calc_has_chars) begin
      res.status = aca_pkg::ST_EMPTY;
    end else if (!op_ok) begin
      res.status = aca_pkg::ST_BAD_MNEM;
    end else if (calc_token < 2'd2) begin
      res.status = aca_pkg::ST_MISSING;
    end else if (calc_bad_digit) begin
      res.status = aca_pkg::ST_BAD_DIGIT;
    end else if (op == aca_pkg::OP_DIV && calc_rhs == '0) begin
      res.status = aca_pkg::ST_DIV_ZERO;
    end else begin
      res.status = aca_pkg::ST_OK;
      case (op)
        aca_pkg::OP_ADD: val = calc_lhs + calc_rhs;
        aca_pkg::OP_SUB: val = calc_lhs - calc_rhs;
        aca_pkg::OP_MUL: val = calc_lhs * calc_rhs;
        default:         val = calc_lhs / calc_rhs;
      endcase
    end
    res.op    = op_ok ? op : aca_pkg::OP_ADD;
    res.value = val;
    pending_results.push_back(res);
    if (res.status != aca_pkg::ST_OK) calc_halted = 1'b1;
    calc_clear_line();
  endtask

  // Advance the model by one accepted byte
  task automatic calc_take_char(input char_t ch);
    if (calc_halted) return;
    if (ch == aca_pkg::CHAR_NL) begin
      calc_end_line();
      return;
    end
    calc_has_chars = 1'b1;
    if (ch == aca_pkg::CHAR_SPACE && calc_token < 2'd2) begin
      calc_token = calc_token + 2'd1;
      return;
    end
    if (calc_token == 2'd0) begin
      if (calc_mnem_len < 3'd3) calc_mnem = {calc_mnem[15:0], ch};
      if (calc_mnem_len < 3'd4) calc_mnem_len = calc_mnem_len + 3'd1;
    end else if (ch >= aca_pkg::CHAR_ZERO && ch <= aca_pkg::CHAR_NINE) begin
      if (calc_token == 2'd1)
        calc_lhs = calc_lhs * 32'd10 + (ch - aca_pkg::CHAR_ZERO);
      else
        calc_rhs = calc_rhs * 32'd10 + (ch - aca_pkg::CHAR_ZERO);
    end else begin
      calc_bad_digit = 1'b1;
    end
  endtask

  task automatic check_result();
    calc_result_t want;
    logic [31:0]  got_value;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result", {29'd0, out_status}, 32'd0);
      return;
    end
    want      = pending_results.pop_front();
    got_value = out_value;
    if (out_status !== want.status)
      report_mismatch("status", {29'd0, out_status}, {29'd0, want.status});
    if (out_opcode !== want.op)
      report_mismatch("opcode", {30'd0, out_opcode}, {30'd0, want.op});
    if (got_value !== want.value)
      report_mismatch("value", got_value, want.value);
  endtask

  // Check result beats first, then feed accepted input beats to the model
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) begin
        calc_take_char(in_char_in);
        chars_taken++;
      end
    end
  end

  // Send one byte; entered and left at a falling edge
  task automatic send_char(input char_t ch);
    while (!no_idle && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= ch;
    // Hold the byte until the block takes it
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Decimal token: empty, extreme, random value or long wrapping digit run
  function automatic string make_operand(input bit want_nonzero);
    string       s;
    logic [31:0] v;
    int          n;
    do begin
      s = "";
      case ($urandom_range(0, 9))
        0: s = "";
        1: s = "4294967295";
        2: s = "0";
        3, 4: begin
          n = $urandom_range(1, 14);
          repeat (n) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        end
        default: s = $sformatf("%0d", $urandom >> $urandom_range(0, 31));
      endcase
      v = '0;
      for (int i = 0; i < s.len(); i++) v = v * 32'd10 + (s[i] - aca_pkg::CHAR_ZERO);
    end while (want_nonzero && v == '0);
    return s;
  endfunction

  task automatic send_random_line();
    aca_pkg::op_t op;
    string        mnem;
    string        lhs;
    string        rhs;
    op = aca_pkg::op_t'($urandom_range(0, 3));
    case (op)
      aca_pkg::OP_ADD: mnem = "ADD";
      aca_pkg::OP_SUB: mnem = "SUB";
      aca_pkg::OP_MUL: mnem = "MUL";
      default:         mnem = "DIV";
    endcase
    lhs = make_operand(1'b0);
    rhs = make_operand(op == aca_pkg::OP_DIV);
    send_text({mnem, " ", lhs, " ", rhs, "\n"});
  endtask

  // Every operation at the edges of the 32-bit range
  task automatic test_operations();
    send_text("ADD 4294967295 1\n");
    send_text("SUB 0 1\n");
    send_text("MUL 65537 65535\n");
    send_text("DIV 4294967295 1\n");
    send_text("DIV 7 4294967295\n");
  endtask

  // Empty tokens, leading zeros and wrapping digit runs
  task automatic test_operand_edges();
    send_text("ADD  9\n");
    send_text("SUB 9 \n");
    send_text("MUL 99999999999 00010\n");
    send_text("DIV 100 7\n");
  endtask

  task automatic test_random_lines(input int char_count);
    int stop_at;
    stop_at = chars_taken + char_count;
    while (chars_taken < stop_at) send_random_line();
  endtask

  // Drop all idling on both sides for a while
  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (25) send_random_line();
    no_idle = 1'b0;
  endtask

  // One error line of a random kind, then bytes the halted block must drop
  task automatic test_error_halt();
    char_t c;
    int    n;
    case ($urandom_range(0, 5))
      0: send_text("\n");
      1: begin
        if ($urandom_range(0, 1) != 0) send_text("MUL\n");
        else send_text("SUB 17\n");
      end
      2: begin
        n = $urandom_range(1, 5);
        repeat (n) begin
          do c = char_t'($urandom_range(0, 255));
          while (c == aca_pkg::CHAR_NL || c == aca_pkg::CHAR_SPACE);
          send_char(c);
        end
        send_text(" 1 2\n");
      end
      3: begin
        if ($urandom_range(0, 1) != 0) send_text("ADD 12 3");
        else send_text("SUB 4");
        do c = char_t'($urandom_range(0, 255));
        while (c == aca_pkg::CHAR_NL ||
               (c >= aca_pkg::CHAR_ZERO && c <= aca_pkg::CHAR_NINE));
        send_char(c);
        send_text(" 9\n");
      end
      4: begin
        case ($urandom_range(0, 2))
          0:       send_text("DIV 77 0\n");
          1:       send_text("DIV 5 \n");
          default: send_text("DIV 1 4294967296\n");
        endcase
      end
      default: begin
        case ($urandom_range(0, 2))
          0:       send_text("ADDX 1 2\n");
          1:       send_text(" ADD 1 2\n");
          default: send_text("add 1 2\n");
        endcase
      end
    endcase
    repeat (80)
      send_char($urandom_range(0, 4) == 0 ? aca_pkg::CHAR_NL
                                          : char_t'($urandom_range(0, 255)));
  endtask

  initial begin
    calc_halted = 1'b0;
    calc_clear_line();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_operations();
    test_operand_edges();
    test_random_lines(RANDOM_CHARS / 2);
    test_back_to_back();
    test_random_lines(RANDOM_CHARS / 3);
    test_error_halt();
    in_valid <= 1'b0;

    // Drain outstanding results, then give the block time for stray beats
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("[ascii_command_alu] OK");
    else
      $display("[ascii_command_alu] ERROR");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/aca_pkg.sv
rtl/aca_alu.sv
rtl/ascii_command_alu.sv
rtl/ascii_command_alu_checker.sv
verif/tb_ascii_command_alu.sv
